// ===== hdl/sgv_pkg.sv =====
// sgv_pkg: shared types and constants for the sphere grid voxelizer.
// Used by sgv_divider, sgv_walker and sphere_grid_voxelizer.
package sgv_pkg;

  localparam logic [1:0] CMD_PAINT    = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  localparam logic [2:0] REG_INTERIOR = 3'd0;
  localparam logic [2:0] REG_STEP     = 3'd1;
  localparam logic [2:0] REG_CORE     = 3'd2;
  localparam logic [2:0] REG_SHELL    = 3'd3;
  localparam logic [2:0] REG_FRACTION = 3'd4;

  localparam logic [15:0] ONE_Q88 = 16'd256;

  localparam int GRID_SIDE = 32;

  localparam int CFG_W  = 24;
  localparam int COORD_W = 34;   // centre +- radius sum
  localparam int DIFF_W  = 27;   // voxel offset, below radius plus step
  localparam int DIST_W  = 54;   // squared distance bound

  typedef struct packed {
    logic [15:0] interior_value;
    logic [23:0] grid_step;
    logic [23:0] core_radius;
    logic [23:0] shell_thickness;
    logic [15:0] surface_fraction;
  } cfg_t;

  typedef struct packed {
    logic surface;
    logic empty;
  } cls_t;

endpackage

// ===== hdl/sgv_divider.sv =====
// sgv_divider: shared restoring divider, one quotient bit per cycle.
// Floor division of a signed numerator by an unsigned step; depends on sgv_pkg.
module sgv_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sgv_pkg::COORD_W-1:0]  num,
  input  logic        [sgv_pkg::CFG_W-1:0]    den,
  output logic                                done,
  output logic signed [sgv_pkg::COORD_W-1:0]  quo,
  output logic                                exact
);

  localparam int N = sgv_pkg::COORD_W;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]       mag;
  logic [N-1:0]       q;
  logic [sgv_pkg::CFG_W:0] rem;
  logic [CW-1:0]      cnt;
  logic               neg;
  logic               busy;
  logic [sgv_pkg::CFG_W:0] trial;
  logic [sgv_pkg::CFG_W:0] shifted;

  assign shifted = {rem[sgv_pkg::CFG_W-1:0], mag[N-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
        neg  <= num[N-1];
        mag  <= num[N-1] ? N'(-num) : N'(num);
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        if (!trial[sgv_pkg::CFG_W]) begin
          rem <= trial;
          q   <= {q[N-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[N-2:0], 1'b0};
        end
        mag <= {mag[N-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor: negative inexact rounds away from zero
  always_comb begin
    exact = (rem == '0);
    if (neg) quo = exact ? -$signed(q) : -$signed(q) - $signed(N'(1));
    else     quo = $signed(q);
  end

endmodule

// ===== hdl/sgv_walker.sv =====
// sgv_walker: sequencer that walks the voxel box of one atom over the grid memory.
// Uses sgv_divider for box bounds and sgv_pkg for types.
module sgv_walker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 cmd,
  input  logic signed [31:0]         ax,
  input  logic signed [31:0]         ay,
  input  logic signed [31:0]         az,
  input  logic [14:0]                addr,
  input  sgv_pkg::cfg_t              cfg,
  output logic                       done,
  output logic [15:0]                rd_value,
  output sgv_pkg::cls_t              cls
);

  localparam int GRID_SIDE = sgv_pkg::GRID_SIDE;
  localparam int SW = $clog2(GRID_SIDE);
  localparam int AW = 3 * SW;
  localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int NW = SW + 1;
  localparam int CNTW = AW + 1;
  localparam int CRW = sgv_pkg::COORD_W;
  localparam int PW = sgv_pkg::COORD_W + sgv_pkg::CFG_W;
  localparam int DIST_WL = sgv_pkg::DIST_W;
  localparam int DFW = sgv_pkg::DIFF_W;
  localparam logic signed [CRW-1:0] ONE_C = CRW'(1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_WDIV  = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_SQ    = 10'b0000010000,
    S_RD    = 10'b0000100000,
    S_ACT   = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_CLR   = 10'b0100000000,
    S_READ  = 10'b1000000000
  } st_t;

  st_t st;
  logic [15:0] mem [CELLS];
  logic [15:0] mem_q;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata;
  logic we;

  logic is_paint;
  logic [23:0] eta;
  logic [sgv_pkg::CFG_W:0] rd;
  logic [DIST_WL-1:0] r2, rd2;

  logic signed [CRW-1:0] cen [3];
  logic signed [CRW-1:0] lo [3];
  logic [NW-1:0] n [3];
  logic [NW-1:0] pos [3];
  logic [1:0] ax_i;
  logic hi_phase;

  logic div_start, div_done, div_exact;
  logic signed [CRW-1:0] div_num, div_quo;

  logic signed [PW-1:0] d [3];
  logic [DIST_WL-1:0] dsq;
  logic [DIST_WL-1:0] sq;
  logic [1:0] m_i;
  logic [AW-1:0] vidx;
  logic [CNTW-1:0] cnt, cov;
  logic emp;
  logic [CNTW+16-1:0] lhs, rhs;

  sgv_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(eta),
    .done(div_done), .quo(div_quo), .exact(div_exact)
  );

  assign div_num = hi_phase ? cen[ax_i] + $signed({1'b0, rd})
                            : cen[ax_i] - $signed({1'b0, rd});
  assign div_start = (st == S_DIV);

  // two multipliers shared over the axes: signed coordinate times step, and squares
  logic signed [PW-1:0] prod;
  logic signed [CRW-1:0] idx_s;
  assign idx_s = lo[m_i] + $signed({{(CRW-NW){1'b0}}, pos[m_i]});
  assign prod = idx_s * $signed({1'b0, eta}) - PW'(cen[m_i]);
  logic signed [DFW-1:0] dsel;
  logic signed [DIST_WL-1:0] sqs;
  assign dsel = d[m_i][DFW-1:0];
  assign sqs = dsel * dsel;
  assign sq = $unsigned(sqs);

  function automatic logic [SW-1:0] wrap(input logic signed [CRW-1:0] v);
    logic signed [CRW-1:0] t;
    t = v + CRW'(GRID_SIDE / 2);
    return t[SW-1:0];
  endfunction

  logic [SW-1:0] wx, wy, wz;
  assign wx = wrap(lo[0] + $signed({{(CRW-NW){1'b0}}, pos[0]}));
  assign wy = wrap(lo[1] + $signed({{(CRW-NW){1'b0}}, pos[1]}));
  assign wz = wrap(lo[2] + $signed({{(CRW-NW){1'b0}}, pos[2]}));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_q <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = vidx;
    wdata = cfg.interior_value;
    raddr = (st == S_IDLE) ? addr[AW-1:0] : vidx;
    if (st == S_CLR) begin
      we = 1'b1;
      waddr = cnt[AW-1:0];
      wdata = '0;
    end else if (st == S_ACT && is_paint && dsq <= rd2) begin
      if (dsq > r2) begin
        we = (mem_q == '0);
        wdata = sgv_pkg::ONE_Q88;
      end else begin
        we = 1'b1;
      end
    end
  end

  assign lhs = {cov, 16'd0};
  assign rhs = cnt * cfg.surface_fraction;

  logic last_z, last_y, last_x;
  assign last_z = (pos[2] == n[2] - 1'b1);
  assign last_y = (pos[1] == n[1] - 1'b1);
  assign last_x = (pos[0] == n[0] - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start) begin
            is_paint <= (cmd == sgv_pkg::CMD_PAINT);
            cen[0] <= CRW'(ax);
            cen[1] <= CRW'(ay);
            cen[2] <= CRW'(az);
            eta <= (cfg.grid_step == '0) ? 24'd1 : cfg.grid_step;
            rd  <= {1'b0, cfg.core_radius} + {1'b0, cfg.shell_thickness};
            ax_i <= '0;
            hi_phase <= 1'b0;
            cnt <= '0;
            cov <= '0;
            emp <= 1'b0;
            cls <= '0;
            rd_value <= '0;
            unique case (cmd)
              sgv_pkg::CMD_PAINT, sgv_pkg::CMD_CLASSIFY: st <= S_DIV;
              sgv_pkg::CMD_READ: st <= S_READ;
              sgv_pkg::CMD_CLEAR: st <= S_CLR;
              default: st <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          rd_value <= (32'(addr) < CELLS) ? mem_q : '0;
          done <= 1'b1;
          st <= S_IDLE;
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt[AW-1:0] == AW'(CELLS - 1)) begin
            cnt <= '0;
            done <= 1'b1;
            st <= S_IDLE;
          end
        end
        S_DIV: begin
          r2  <= DIST_WL'(cfg.core_radius) * DIST_WL'(cfg.core_radius);
          rd2 <= DIST_WL'(rd) * DIST_WL'(rd);
          st <= S_WDIV;
        end
        S_WDIV: begin
          if (div_done) begin
            if (!hi_phase) begin
              lo[ax_i] <= div_quo;
              hi_phase <= 1'b1;
              st <= S_DIV;
            end else begin
              begin : span_b
                logic signed [CRW-1:0] h, sp;
                h = div_exact ? div_quo : div_quo + ONE_C;
                sp = h - lo[ax_i] + ONE_C;
                n[ax_i] <= (sp > CRW'(GRID_SIDE)) ? NW'(GRID_SIDE) : NW'(sp);
              end
              hi_phase <= 1'b0;
              if (ax_i == 2'd2) begin
                pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
                m_i <= '0;
                st <= S_MUL;
              end else begin
                ax_i <= ax_i + 1'b1;
                st <= S_DIV;
              end
            end
          end
        end
        S_MUL: begin
          d[m_i] <= prod;
          if (m_i == 2'd2) begin
            m_i <= '0;
            dsq <= '0;
            st <= S_SQ;
          end else m_i <= m_i + 1'b1;
        end
        S_SQ: begin
          dsq <= dsq + sq;
          if (m_i == 2'd2) begin
            vidx <= {wx, wy, wz};
            st <= S_RD;
          end else m_i <= m_i + 1'b1;
        end
        S_RD: st <= S_ACT;
        S_ACT: begin
          if (!is_paint && dsq <= rd2 && dsq > r2) begin
            cnt <= cnt + 1'b1;
            if (mem_q == sgv_pkg::ONE_Q88) cov <= cov + 1'b1;
            if (mem_q == '0) emp <= 1'b1;
          end
          m_i <= '0;
          st <= S_MUL;
          if (!last_z) pos[2] <= pos[2] + 1'b1;
          else begin
            pos[2] <= '0;
            if (!last_y) pos[1] <= pos[1] + 1'b1;
            else begin
              pos[1] <= '0;
              if (!last_x) pos[0] <= pos[0] + 1'b1;
              else st <= S_FIN;
            end
          end
        end
        S_FIN: begin
          cls.surface <= !is_paint && (cnt != '0) && (lhs > rhs);
          cls.empty   <= !is_paint && emp;
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> st == S_IDLE) else $error("done outside idle");
  a_clr_write: assert property (@(posedge clk) disable iff (rst)
    st == S_CLR |-> we && wdata == '0) else $error("clear pass not writing");
  a_no_paint_cls: assert property (@(posedge clk) disable iff (rst)
    (st == S_ACT && !is_paint) |-> !we) else $error("classify wrote grid");

endmodule

// ===== hdl/sphere_grid_voxelizer.sv =====
// Channel   | valid     | stall     | payload
// in        | in_valid  | in_stall  | command, atom_x/y/z, voxel_address
// out       | out_valid | out_stall | voxel_value, is_surface, empty_shell_seen
// cfg       | cfg_we    | -         | cfg_index, cfg_data
// Paint/classify: per-axis bound division, then S_MUL, S_SQ, S_RD, S_ACT per voxel.
// Then S_FIN. Read uses S_READ; clear sweeps GRID_SIDE^3 entries, one per cycle.
// Reset clears control only; the grid starts as zero through a reset-time clear.
// A word waits in the output register while out_stall is high; in_stall holds.
module sphere_grid_voxelizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] atom_x,
  input  logic signed [31:0] atom_y,
  input  logic signed [31:0] atom_z,
  input  logic [14:0]        voxel_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] voxel_value,
  output logic               is_surface,
  output logic               empty_shell_seen,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  sgv_pkg::cfg_t cfg;
  sgv_pkg::cls_t cls;
  logic busy, boot, start, done;
  logic [1:0] wcmd;
  logic [15:0] rv;

  assign in_stall = busy || boot || out_valid;
  assign start = boot ? 1'b1 : (in_valid && !in_stall);
  assign wcmd = boot ? sgv_pkg::CMD_CLEAR : command;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interior_value   <= 16'd256;
      cfg.grid_step        <= 24'd65536;
      cfg.core_radius      <= 24'd131072;
      cfg.shell_thickness  <= 24'd65536;
      cfg.surface_fraction <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgv_pkg::REG_INTERIOR: cfg.interior_value   <= cfg_data[15:0];
        sgv_pkg::REG_STEP:     cfg.grid_step        <= cfg_data;
        sgv_pkg::REG_CORE:     cfg.core_radius      <= cfg_data;
        sgv_pkg::REG_SHELL:    cfg.shell_thickness  <= cfg_data;
        sgv_pkg::REG_FRACTION: cfg.surface_fraction <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic booting;
  always_ff @(posedge clk) begin
    if (rst) begin
      boot <= 1'b1;
      booting <= 1'b0;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (boot) begin
        boot <= 1'b0;
        booting <= 1'b1;
        busy <= 1'b1;
      end else if (start) busy <= 1'b1;
      if (done) begin
        busy <= 1'b0;
        if (booting) booting <= 1'b0;
        else begin
          out_valid <= 1'b1;
          voxel_value <= rv;
          is_surface <= cls.surface;
          empty_shell_seen <= cls.empty;
        end
      end else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  sgv_walker u_walk (
    .clk(clk), .rst(rst), .start(start), .cmd(wcmd),
    .ax(atom_x), .ay(atom_y), .az(atom_z), .addr(voxel_address),
    .cfg(cfg), .done(done), .rd_value(rv), .cls(cls)
  );

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    done && !booting |=> out_valid) else $error("result lost");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("accept while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without item");

endmodule
